[hw/rtl/fifo_evicting_key_value_store_macros.svh]
// ---------------------------------------------------------------------------
// fekv assertion macros
// shared concurrent assertion forms, removable with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef FIFO_EVICTING_KEY_VALUE_STORE_MACROS_SVH
`define FIFO_EVICTING_KEY_VALUE_STORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FEKV_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("fekv same-cycle check failed");
`define FEKV_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("fekv next-cycle check failed");
`else
`define FEKV_ASSERT_SAME(label, clk, rst_n, a, b)
`define FEKV_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[hw/rtl/fekv_pkg.sv]
// ---------------------------------------------------------------------------
// fekv package
// request codes and the controller/datapath command and status types
// ---------------------------------------------------------------------------
package fekv_pkg;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_FORGET = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [7:0] LIMIT_AT_RESET = 8'd120;

    localparam int KEY_W = 64;
    localparam int VAL_W = 32;

    typedef struct packed {
        logic accept;
        logic scan;
        logic ev_rd;
        logic ev_wr;
        logic ins;
        logic upd;
        logic sh_rd;
        logic sh_wr;
        logic fg_end;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic       scan_done;
        logic       found;
        logic       full;
        logic       over_lim;
        logic       sh_first;
        logic       sh_more;
        logic       out_free;
        logic [1:0] op;
    } t_status;

endpackage

[hw/rtl/fekv_ram.sv]
// ---------------------------------------------------------------------------
// fekv generic ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module fekv_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/fekv_datapath.sv]
// ---------------------------------------------------------------------------
// fekv datapath
// circular entry store in age order, scan compare, counters, result register
// ---------------------------------------------------------------------------
module fekv_datapath import fekv_pkg::*; #(
    parameter int CAPACITY = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_op,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    input  logic              i_cfg_wr,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_out_stall,
    input  t_cmd              i_cmd,
    output t_status           o_st,
    output logic              o_out_valid,
    output logic              o_hit,
    output logic [VAL_W-1:0]  o_read_value,
    output logic              o_evicted,
    output logic [KEY_W-1:0]  o_evicted_key,
    output logic [7:0]        o_entry_count
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > 8) ? CW : 8;
    localparam int PW = AW + 1;
    localparam int DW = KEY_W + VAL_W;

    logic [7:0]       r_limit;
    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_scan;
    logic [CW-1:0]    r_sp;
    logic             r_cmp_valid;
    logic [CW-1:0]    r_cmp_pos;
    logic             r_found;
    logic [VAL_W-1:0] r_fval;
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic             r_ev;
    logic [KEY_W-1:0] r_evk;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [DW-1:0]    wdata;
    logic [AW-1:0]    raddr;
    logic [DW-1:0]    rdata;
    logic [MW-1:0]    lim_eff;
    logic [MW-1:0]    cnt_ext;
    logic [CW-1:0]    sp_next;

    // logical age position to physical slot
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] p);
        logic [PW-1:0] s;
        s = PW'(head) + PW'(p);
        if (s >= PW'(CAPACITY)) begin
            s = s - PW'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign sp_next = r_sp + CW'(1);
    assign cnt_ext = MW'(r_count);

    always_comb begin
        if (r_limit == 8'd0) begin
            lim_eff = MW'(1);
        end else if (MW'(r_limit) > MW'(CAPACITY)) begin
            lim_eff = MW'(CAPACITY);
        end else begin
            lim_eff = MW'(r_limit);
        end
    end

    always_comb begin
        raddr = r_head;
        if (i_cmd.scan) begin
            raddr = phys(r_head, r_scan);
        end else if (i_cmd.sh_rd) begin
            raddr = phys(r_head, sp_next);
        end else if (i_cmd.ev_rd) begin
            raddr = r_head;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = phys(r_head, r_sp);
        wdata = rdata;
        if (i_cmd.ins) begin
            we    = 1'b1;
            waddr = phys(r_head, r_count);
            wdata = {r_key, r_val};
        end else if (i_cmd.upd) begin
            we    = 1'b1;
            wdata = {r_key, r_val};
        end else if (i_cmd.sh_wr) begin
            we    = 1'b1;
        end
    end

    fekv_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_AT_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
            r_ev        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_limit <= i_cfg_data;
            end
            r_cmp_valid <= i_cmd.scan && (r_scan < r_count);
            if (i_cmd.accept) begin
                r_found <= 1'b0;
                r_ev    <= 1'b0;
            end else if (r_cmp_valid && rdata[DW-1:VAL_W] == r_key) begin
                r_found <= 1'b1;
            end
            if (i_cmd.ev_wr) begin
                r_ev <= 1'b1;
                r_head <= (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
            end
            if (i_cmd.ev_wr || i_cmd.fg_end) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.ins) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_key  <= i_key;
            r_val  <= i_value;
            r_scan <= '0;
            r_evk  <= '0;
        end
        if (i_cmd.scan && (r_scan < r_count)) begin
            r_scan    <= r_scan + CW'(1);
            r_cmp_pos <= r_scan;
        end
        if (r_cmp_valid && rdata[DW-1:VAL_W] == r_key) begin
            r_sp   <= r_cmp_pos;
            r_fval <= rdata[VAL_W-1:0];
        end else if (i_cmd.sh_wr) begin
            r_sp <= sp_next;
        end
        if (i_cmd.ev_wr && !r_ev) begin
            r_evk <= rdata[DW-1:VAL_W];
        end
        if (i_cmd.out_load) begin
            o_hit          <= (r_op != OP_NONE) && r_found;
            o_read_value   <= (r_op == OP_GET && r_found) ? r_fval : '0;
            o_evicted      <= r_ev;
            o_evicted_key  <= r_evk;
            o_entry_count  <= cnt_ext[7:0];
        end
    end

    always_comb begin
        o_st.scan_done = (r_scan == r_count) && !r_cmp_valid;
        o_st.found     = r_found;
        o_st.full      = (r_count == CW'(CAPACITY));
        o_st.over_lim  = cnt_ext > lim_eff;
        o_st.sh_first  = sp_next < r_count;
        o_st.sh_more   = ({1'b0, r_sp} + (CW+1)'(2)) < {1'b0, r_count};
        o_st.out_free  = !o_out_valid || !i_out_stall;
        o_st.op        = r_op;
    end
endmodule

[hw/rtl/fekv_ctrl.sv]
// ---------------------------------------------------------------------------
// fekv controller
// sequences scan, update, insert, eviction and compaction of one request
// ---------------------------------------------------------------------------
module fekv_ctrl import fekv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_st,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_EV_RD  = 4'd3;
    localparam logic [3:0] S_EV_WR  = 4'd4;
    localparam logic [3:0] S_INS    = 4'd5;
    localparam logic [3:0] S_UPD    = 4'd6;
    localparam logic [3:0] S_LIM    = 4'd7;
    localparam logic [3:0] S_SH_RD  = 4'd8;
    localparam logic [3:0] S_SH_WR  = 4'd9;
    localparam logic [3:0] S_FG_END = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_ins, n_ins;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ins   = r_ins;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_st.scan_done) begin
                    o_cmd.scan = 1'b0;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_OUT;
                if (i_st.op == OP_PUT) begin
                    if (i_st.found) begin
                        n_state = S_UPD;
                    end else if (i_st.full) begin
                        n_ins   = 1'b1;
                        n_state = S_EV_RD;
                    end else begin
                        n_state = S_INS;
                    end
                end else if (i_st.op == OP_FORGET && i_st.found) begin
                    n_state = i_st.sh_first ? S_SH_RD : S_FG_END;
                end
            end
            S_EV_RD: begin
                o_cmd.ev_rd = 1'b1;
                n_state     = S_EV_WR;
            end
            S_EV_WR: begin
                o_cmd.ev_wr = 1'b1;
                n_ins       = 1'b0;
                n_state     = r_ins ? S_INS : S_LIM;
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = S_LIM;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_LIM;
            end
            S_LIM: begin
                n_state = i_st.over_lim ? S_EV_RD : S_OUT;
            end
            S_SH_RD: begin
                o_cmd.sh_rd = 1'b1;
                n_state     = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = i_st.sh_more ? S_SH_RD : S_FG_END;
            end
            S_FG_END: begin
                o_cmd.fg_end = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ins   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ins   <= n_ins;
        end
    end
endmodule

[hw/rtl/fifo_evicting_key_value_store.sv]
// ---------------------------------------------------------------------------
// fifo evicting key-value store
// bounded key table in insertion order with oldest-first eviction
// ---------------------------------------------------------------------------
// - request channel i_in_valid / o_in_stall carries op, key and value; a
//   transaction completes when valid is high and stall is low
// - result channel o_out_valid / i_out_stall returns one result per request
// - configuration channel i_cfg_valid / o_cfg_ready writes the entry limit;
//   ready is always high, write only while no request is in flight
// - after acceptance the key scan reads the entry memory one address per
//   cycle; any put or forget steps follow, and then the result is loaded
// - a put updates or inserts, a new key on a full table first evicts the
//   oldest, and entries over the limit are evicted oldest first; a forget
//   hit moves each later entry down one slot
// - one request at a time: stall drops the cycle after the result loads
// - synchronous active low reset empties the table, limit returns to 120
// - a held result keeps the block in its final state until it is taken
// ---------------------------------------------------------------------------
`include "fifo_evicting_key_value_store_macros.svh"

module fifo_evicting_key_value_store import fekv_pkg::*; #(
    parameter int CAPACITY = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    // configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output logic [VAL_W-1:0]  o_read_value,
    output logic              o_evicted,
    output logic [KEY_W-1:0]  o_evicted_key,
    output logic [7:0]        o_entry_count
);
    t_cmd    cmd;
    t_status st;

    // limit register always takes the write
    assign o_cfg_ready = 1'b1;

    fekv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    fekv_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_cfg_wr      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_st          (st),
        .o_out_valid   (o_out_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .o_entry_count (o_entry_count)
    );

    // a transaction always occupies the controller for at least the scan
    `FEKV_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // no eviction reported means no evicted key
    `FEKV_ASSERT_SAME(a_evk_zero, i_clk, i_rst_n, o_out_valid && !o_evicted, o_evicted_key == '0)
    // a nonzero read value only comes from a get hit, which never evicts
    `FEKV_ASSERT_SAME(a_read_from_hit, i_clk, i_rst_n, o_out_valid && o_read_value != '0, o_hit && !o_evicted)
    // the result register loads only once the request is finished
    `FEKV_ASSERT_SAME(a_load_in_flight, i_clk, i_rst_n, cmd.out_load, o_in_stall && !cmd.accept)
endmodule

[test/fifo_evicting_key_value_store_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fifo evicting key-value store testbench
// drives put, get and forget requests against a behavioural table kept in
// insertion order, and checks every result field against its prediction
// ---------------------------------------------------------------------------
module fifo_evicting_key_value_store_tb;
    import fekv_pkg::*;

    localparam int CAP = 128;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [7:0]       entry_count;
    } t_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [1:0]       i_op;
    logic [KEY_W-1:0] i_key;
    logic [VAL_W-1:0] i_value;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_data;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_hit;
    logic [VAL_W-1:0] o_read_value;
    logic             o_evicted;
    logic [KEY_W-1:0] o_evicted_key;
    logic [7:0]       o_entry_count;

    fifo_evicting_key_value_store #(.CAPACITY(CAP)) dut (.*);

    // behavioural table: keys and values listed oldest first
    logic [KEY_W-1:0] tbl_keys[$];
    logic [VAL_W-1:0] tbl_vals[$];
    logic [7:0]       limit_reg;
    t_result          pending_results[$];

    int errors;
    int sent;
    int received;
    int send_idle_pct;
    int recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // table lookup: position of key, or -1
    function automatic int key_pos(logic [KEY_W-1:0] k);
        foreach (tbl_keys[p])
            if (tbl_keys[p] == k) return p;
        return -1;
    endfunction

    // predicted result of one request, updating the table
    function automatic t_result table_request(logic [1:0] op, logic [KEY_W-1:0] k,
                                              logic [VAL_W-1:0] v);
        t_result r;
        int      p;
        int      lim;
        r = '0;
        p = key_pos(k);
        case (op)
            OP_PUT: begin
                lim = limit_reg;
                if (lim < 1) lim = 1;
                if (lim > CAP) lim = CAP;
                r.hit = (p >= 0);
                if (p >= 0) begin
                    tbl_vals[p] = v;
                end else begin
                    // full table: oldest goes to make room
                    if (tbl_keys.size() >= CAP) begin
                        r.evicted     = 1'b1;
                        r.evicted_key = tbl_keys[0];
                        tbl_keys.delete(0);
                        tbl_vals.delete(0);
                    end
                    tbl_keys.insert(tbl_keys.size(), k);
                    tbl_vals.insert(tbl_vals.size(), v);
                end
                // trim down to the limit, reporting the first key pushed out
                while (tbl_keys.size() > lim) begin
                    if (!r.evicted) begin
                        r.evicted     = 1'b1;
                        r.evicted_key = tbl_keys[0];
                    end
                    tbl_keys.delete(0);
                    tbl_vals.delete(0);
                end
            end
            OP_GET: begin
                if (p >= 0) begin
                    r.hit        = 1'b1;
                    r.read_value = tbl_vals[p];
                end
            end
            OP_FORGET: begin
                if (p >= 0) begin
                    r.hit = 1'b1;
                    tbl_keys.delete(p);
                    tbl_vals.delete(p);
                end
            end
            default: ;
        endcase
        r.entry_count = 8'(tbl_keys.size());
        return r;
    endfunction

    // send one request transaction and record its prediction
    task automatic send_request(logic [1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_key      <= k;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.insert(pending_results.size(), table_request(op, k, v));
        sent++;
    endtask

    // stall driver on the result channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            received++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0h got %0h", want.hit, o_hit);
                    errors++;
                end
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %0h got %0h", want.read_value, o_read_value);
                    errors++;
                end
                if (o_evicted !== want.evicted) begin
                    $error("evicted: expected %0h got %0h", want.evicted, o_evicted);
                    errors++;
                end
                if (o_evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected %0h got %0h",
                           want.evicted_key, o_evicted_key);
                    errors++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d got %0d",
                           want.entry_count, o_entry_count);
                    errors++;
                end
            end
        end
    end

    // wait for the block to fall idle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // limit write, only while idle
    task automatic write_limit(logic [7:0] lim);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        limit_reg = lim;
        i_cfg_valid <= 1'b0;
    endtask

    // random key from a small pool so that hits are common, sometimes wide
    function automatic logic [KEY_W-1:0] pick_key(int pool);
        if ($urandom_range(9) == 0) return {$urandom, $urandom};
        return {32'hA5C3_0000 ^ $urandom_range(1), 32'(($urandom_range(pool - 1)) << 3)};
    endfunction

    task automatic test_directed();
        send_request(OP_GET, 64'h0, 32'h0);                   // get on empty table
        send_request(OP_FORGET, 64'h0, 32'h0);                // forget miss
        send_request(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_PUT, 64'h0, 32'h0);
        send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234);
        send_request(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5555_AAAA); // overwrite
        send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_request(OP_NONE, 64'h0, 32'hFFFF_FFFF);          // ignored request
        send_request(OP_FORGET, 64'h0, 32'h0);
        send_request(OP_GET, 64'h0, 32'h0);
        for (int i = 0; i < 4; i++) send_request(OP_PUT, 64'(i + 100), 32'(i));
        write_limit(8'd2);                                    // lowered below count
        send_request(OP_GET, 64'd101, 32'h0);                 // gets never evict
        send_request(OP_PUT, 64'd200, 32'd7);                 // evicts the excess
        write_limit(8'd0);                                    // zero acts as one
        send_request(OP_PUT, 64'd201, 32'd8);
        send_request(OP_PUT, 64'd201, 32'd9);
    endtask

    // fill past capacity with limit above the table size
    task automatic test_full_table();
        write_limit(8'd255);
        for (int i = 0; i < CAP + 6; i++) send_request(OP_PUT, 64'(i * 977 + 5), $urandom);
        for (int i = 0; i < 6; i++) send_request(OP_GET, 64'(i * 977 + 5), 32'h0);
        write_limit(8'd128);
        send_request(OP_PUT, 64'd42, 32'd1);
        write_limit(8'd1);
        send_request(OP_PUT, 64'd43, 32'd2);
    endtask

    task automatic test_random(int n, int pool);
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: op = OP_PUT;
                4, 5, 6:    op = OP_GET;
                7, 8:       op = OP_FORGET;
                default:    op = OP_NONE;
            endcase
            send_request(op, pick_key(pool), $urandom);
        end
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 11; recv_idle_pct = 88;
        write_limit(8'd120);
        test_random(200, 160);
        write_limit(8'd16);
        test_random(200, 40);
        send_idle_pct = 88; recv_idle_pct = 11;
        write_limit(8'd5);
        test_random(200, 12);
        write_limit(8'd200);
        test_random(200, 200);
        send_idle_pct = 0; recv_idle_pct = 0;
        write_limit(8'd64);
        test_random(200, 96);
        write_limit(8'd1);
        test_random(150, 4);
    endtask

    initial begin
        errors = 0; sent = 0; received = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        limit_reg   = LIMIT_AT_RESET;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_GET;
        i_key       = '0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_idle_phases();
        drain();
        repeat (300) @(posedge i_clk);
        $display("covered %0d requests and %0d results over several entry limits", sent, received);
        $display("including eviction, overwrite, forget and full-table cases");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // overall timeout
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
